>>> hw/rtl/assert_macros.svh
// assertion macros used by the rasterizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge out of reset
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`else

`define CHK_SAME(lbl, clk, rstn, ante, cons)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/lrast_pkg.sv
// shared types and constants of the line rasterizer
`default_nettype none

package lrast_pkg;

  // coordinate width and derived widths
  localparam int COORD_BITS = 10;
  localparam int COLOR_BITS = 16;
  localparam int ACC_BITS   = COORD_BITS + 2;
  localparam int LEFT_BITS  = COORD_BITS + 1;
  localparam int KIND_BITS  = 2;

  // stream word widths, padded to whole bytes
  localparam int IN_RAW_W    = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // input word kinds
  localparam logic [KIND_BITS-1:0] KIND_LINE = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_RECT = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_STEP = 2'd2;

  // rectangle edges in drawing order
  localparam logic [1:0] SEG_TOP    = 2'd0;
  localparam logic [1:0] SEG_LEFT   = 2'd1;
  localparam logic [1:0] SEG_BOTTOM = 2'd2;
  localparam logic [1:0] SEG_RIGHT  = 2'd3;

  // per-axis step direction, two's complement
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_INC  = 2'd1;
  localparam logic [1:0] DIR_DEC  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // latch endpoints and color
    logic rect;   // load is a rectangle
    logic setup;  // compute line parameters of the current edge
    logic step;   // emit one pixel and advance
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic seg_last;  // next pixel is the final one of this edge or line
    logic more_seg;  // rectangle edges remain after this one
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/lrast_ctrl.sv
// state machine sequencing loads, edge setup and pixel steps
`default_nettype none

module lrast_ctrl
  import lrast_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [KIND_BITS-1:0] in_kind,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output dp_cmd_t                   cmd,
  input  wire dp_sts_t              sts
);

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   is_load;

  // input is held off during edge setup and while the output word waits
  assign in_tready = (state_r != ST_SETUP) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign is_load   = (in_kind == KIND_LINE) || (in_kind == KIND_RECT);

  // commands to the datapath
  always_comb begin
    cmd.load  = in_acc && is_load;
    cmd.rect  = (in_kind == KIND_RECT);
    cmd.setup = (state_r == ST_SETUP);
    cmd.step  = in_acc && (in_kind == KIND_STEP) && (state_r == ST_RUN);
  end

  // next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.load) begin
          state_nxt = ST_SETUP;
        end else if (cmd.step && sts.seg_last) begin
          state_nxt = sts.more_seg ? ST_SETUP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/lrast_dp.sv
// datapath: endpoints, line parameters, error accumulators and output word
`default_nettype none

module lrast_dp
  import lrast_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // x_start, y_start, x_end, y_end, color
  input  wire dp_cmd_t                cmd,
  output dp_sts_t                     sts,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // pixel_x, pixel_y, pixel_color, pad
  output logic                        out_tlast   // last_of_shape
);

  // latched shape
  logic [COORD_BITS-1:0] xs_r, ys_r, xe_r, ye_r;
  logic [COLOR_BITS-1:0] color_r;
  logic                  rect_r;
  logic [1:0]            seg_r;

  // current line
  logic [COORD_BITS-1:0] cur_col_r, cur_row_r;
  logic [COORD_BITS-1:0] adx_r, ady_r, span_r;
  logic [1:0]            dir_col_r, dir_row_r;
  logic [ACC_BITS-1:0]   acc_col_r, acc_row_r;
  logic [LEFT_BITS-1:0]  left_r;

  // output word
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [COLOR_BITS-1:0] pcolor_r;
  logic                  plast_r;

  // edge endpoint selection
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [COORD_BITS-1:0] adx_nxt, ady_nxt, span_nxt;
  logic [1:0]            dir_col_nxt, dir_row_nxt;

  // step arithmetic
  logic [ACC_BITS-1:0]   sum_col, sum_row, span_ext;
  logic                  mv_col, mv_row;
  logic [COORD_BITS-1:0] col_nxt, row_nxt;

  always_comb begin
    ax = xs_r;
    ay = ys_r;
    bx = xe_r;
    by = ye_r;
    if (rect_r) begin
      case (seg_r)
        SEG_TOP: begin
          by = ys_r;
        end
        SEG_LEFT: begin
          bx = xs_r;
        end
        SEG_BOTTOM: begin
          ay = ye_r;
        end
        SEG_RIGHT: begin
          ax = xe_r;
        end
        default: begin
          ax = xs_r;
        end
      endcase
    end
  end

  // per-axis magnitude and direction, then the major span
  always_comb begin
    if (bx > ax) begin
      adx_nxt     = bx - ax;
      dir_col_nxt = DIR_INC;
    end else if (bx == ax) begin
      adx_nxt     = '0;
      dir_col_nxt = DIR_NONE;
    end else begin
      adx_nxt     = ax - bx;
      dir_col_nxt = DIR_DEC;
    end
    if (by > ay) begin
      ady_nxt     = by - ay;
      dir_row_nxt = DIR_INC;
    end else if (by == ay) begin
      ady_nxt     = '0;
      dir_row_nxt = DIR_NONE;
    end else begin
      ady_nxt     = ay - by;
      dir_row_nxt = DIR_DEC;
    end
    span_nxt = (adx_nxt > ady_nxt) ? adx_nxt : ady_nxt;
  end

  // error accumulators and coordinate moves
  always_comb begin
    span_ext = {2'b00, span_r};
    sum_col  = acc_col_r + {2'b00, adx_r};
    sum_row  = acc_row_r + {2'b00, ady_r};
    mv_col   = sum_col > span_ext;
    mv_row   = sum_row > span_ext;
    col_nxt  = cur_col_r;
    row_nxt  = cur_row_r;
    if (mv_col && dir_col_r == DIR_INC) begin
      col_nxt = cur_col_r + COORD_BITS'(1);
    end else if (mv_col && dir_col_r == DIR_DEC) begin
      col_nxt = cur_col_r - COORD_BITS'(1);
    end
    if (mv_row && dir_row_r == DIR_INC) begin
      row_nxt = cur_row_r + COORD_BITS'(1);
    end else if (mv_row && dir_row_r == DIR_DEC) begin
      row_nxt = cur_row_r - COORD_BITS'(1);
    end
  end

  always_comb begin
    sts.seg_last = (left_r == LEFT_BITS'(1));
    sts.more_seg = rect_r && (seg_r != SEG_RIGHT);
  end

  // shape latch and edge advance
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r    <= in_tdata[COORD_BITS-1:0];
      ys_r    <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      xe_r    <= in_tdata[3*COORD_BITS-1:2*COORD_BITS];
      ye_r    <= in_tdata[4*COORD_BITS-1:3*COORD_BITS];
      color_r <= in_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
      rect_r  <= cmd.rect;
      seg_r   <= SEG_TOP;
    end else if (cmd.step && sts.seg_last && sts.more_seg) begin
      seg_r <= seg_r + 2'd1;
    end
  end

  // line parameters and per-pixel update
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cur_col_r <= ax;
      cur_row_r <= ay;
      adx_r     <= adx_nxt;
      ady_r     <= ady_nxt;
      dir_col_r <= dir_col_nxt;
      dir_row_r <= dir_row_nxt;
      span_r    <= span_nxt;
      acc_col_r <= '0;
      acc_row_r <= '0;
      left_r    <= {1'b0, span_nxt} + LEFT_BITS'(1);
    end else if (cmd.step) begin
      cur_col_r <= col_nxt;
      cur_row_r <= row_nxt;
      acc_col_r <= mv_col ? (sum_col - span_ext) : sum_col;
      acc_row_r <= mv_row ? (sum_row - span_ext) : sum_row;
      left_r    <= left_r - LEFT_BITS'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      px_r     <= cur_col_r;
      py_r     <= cur_row_r;
      pcolor_r <= color_r;
      plast_r  <= sts.seg_last && !sts.more_seg;
    end
  end

  assign out_tdata = {{(OUT_TDATA_W-OUT_RAW_W){1'b0}}, pcolor_r, py_r, px_r};
  assign out_tlast = plast_r;

endmodule

`default_nettype wire

>>> hw/rtl/line_rasterizer_top.sv
// line and rectangle rasterizer, top level
//
//  channel  ports            word contents (lowest bit first)
//  in       in_t*            tuser: kind; tdata: x_start, y_start, x_end, y_end, color
//  out      out_t*           tdata: pixel_x, pixel_y, pixel_color; tlast: last_of_shape
//
// a step word yields one pixel word while a shape is drawn.
// a load is followed by a setup state of the edge datapath that holds input off;
// each further rectangle edge passes through that setup state again.
// rst_n is synchronous and clears the state machine and the output valid flag.
// in_tready drops while an output word waits and out_tready is low.
`default_nettype none
`include "assert_macros.svh"

module line_rasterizer_top
  import lrast_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // x_start, y_start, x_end, y_end, color
  input  wire logic [KIND_BITS-1:0]   in_tuser,   // kind
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // pixel_x, pixel_y, pixel_color, pad
  output logic                        out_tlast   // last_of_shape
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  lrast_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath
  lrast_dp u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // checks
  `CHK_SAME(a_setup_blocks_in, clk, rst_n, cmd.setup, !in_tready)
  `CHK_NEXT(a_step_gives_word, clk, rst_n, cmd.step, out_tvalid)
  `CHK_NEXT(a_load_then_setup, clk, rst_n, cmd.load, cmd.setup)
  `CHK_NEXT(a_setup_one_cycle, clk, rst_n, cmd.setup, !cmd.setup)

endmodule

`default_nettype wire
